// ===== rtl/core/kbsc_pkg.sv =====
`timescale 1ns / 1ps

package kbsc_pkg;

   // stream word layout
   localparam int REQ_TDATA_W = 40;  // offset [31:0], data_in [39:32]
   localparam int RSP_TDATA_W = 8;   // data_out [7:0]

   // function codes carried on req_tuser
   localparam logic FUNC_INIT = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   // start key slot picked by offset mod 3
   localparam logic [1:0] KEY_SEL_FIRST = 2'd0;
   localparam logic [1:0] KEY_SEL_MIX   = 2'd1;

   localparam int SEED_BYTES     = 32;
   localparam int SEED_CONST_LEN = 32;
   localparam logic [5:0] SEED_LAST = 6'(SEED_BYTES - 1);

   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] MIX_MULT        = 32'd290333451;
   localparam logic [31:0] START_KEY_FIRST = 32'd305419896;
   localparam logic [31:0] START_KEY_MIX   = 32'd591751049;
   localparam logic [31:0] START_KEY_LAST  = 32'd878082192;

   // first seed character sits in the top byte
   localparam logic [8*SEED_CONST_LEN-1:0] SEED_STRING = "WgQgJ3vyYvAAkHHhFdueKh2ssZli8Ko4";

   typedef struct packed {
      logic capture;    // take payload of an accepted word
      logic load_keys;  // load start keys and offset
      logic step_a;     // first key crc step
      logic step_b;     // mix key multiply
      logic step_c;     // mix key finish, last key crc step
      logic use_seed;   // byte source is the seed table
      logic pos_clr;
      logic pos_inc;
      logic out_load;   // load result word
   } kbsc_cmd_type;

   typedef struct packed {
      logic pos_last;
   } kbsc_stat_type;

   // one byte of reflected crc-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = {24'h0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r ^ (crc >> 8);
   endfunction

   // base-4 digits each weigh 1 mod 3, so fold digit sums
   function automatic logic [1:0] mod3(input logic [31:0] v);
      logic [5:0] s;
      logic [3:0] s2;
      logic [2:0] s3;
      s = '0;
      for (int k = 0; k < 16; k++) begin
         s = s + 6'(v[2*k +: 2]);
      end
      s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
      return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
   endfunction

   // seed bytes past the constant string are zero
   function automatic logic [7:0] seed_byte(input logic [5:0] pos);
      logic [4:0] idx;
      idx = 5'(SEED_CONST_LEN - 1) - pos[4:0];
      if (7'(pos) < 7'(SEED_CONST_LEN)) begin
         return SEED_STRING[{idx, 3'b000} +: 8];
      end
      return 8'h00;
   endfunction

endpackage

// ===== rtl/core/kbsc_ctrl.sv =====
`timescale 1ns / 1ps

module kbsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output kbsc_pkg::kbsc_cmd_type cmd,
   input  kbsc_pkg::kbsc_stat_type stat
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INIT   = 5'b00010,
      ST_STEP_A = 5'b00100,
      ST_STEP_B = 5'b01000,
      ST_STEP_C = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      seed_ff, seed_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      seed_in  = seed_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (req_tuser == kbsc_pkg::FUNC_INIT) begin
                  seed_in  = 1'b1;
                  state_in = ST_INIT;
               end else begin
                  seed_in  = 1'b0;
                  state_in = ST_STEP_A;
               end
            end
         end
         ST_INIT: begin
            cmd.load_keys = 1'b1;
            cmd.pos_clr   = 1'b1;
            state_in      = ST_STEP_A;
         end
         ST_STEP_A: begin
            // a data byte waits here until the result slot is free
            if (seed_ff || out_free) begin
               cmd.step_a   = 1'b1;
               cmd.use_seed = seed_ff;
               cmd.out_load = !seed_ff;
               state_in     = ST_STEP_B;
            end
         end
         ST_STEP_B: begin
            cmd.step_b = 1'b1;
            state_in   = ST_STEP_C;
         end
         ST_STEP_C: begin
            cmd.step_c = 1'b1;
            if (seed_ff && !stat.pos_last) begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_STEP_A;
            end else begin
               cmd.pos_clr = seed_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/kbsc_datapath.sv =====
`timescale 1ns / 1ps

module kbsc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kbsc_pkg::kbsc_cmd_type               cmd,
   output kbsc_pkg::kbsc_stat_type              stat,
   input  logic [kbsc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tlast,
   output logic [kbsc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   logic [31:0] first_ff, first_in;
   logic [31:0] mix_ff, mix_in;
   logic [31:0] last_ff, last_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] prod_ff;
   logic [31:0] offset_ff;
   logic [7:0]  data_ff;
   logic        eor_ff;
   logic [7:0]  out_data_ff;
   logic        out_eor_ff;

   logic [1:0]  key_sel;
   logic [7:0]  byte_src;
   logic [15:0] ks_t;
   logic [15:0] ks_prod;
   logic [31:0] mix_next;

   assign key_sel  = kbsc_pkg::mod3(offset_ff);
   assign byte_src = cmd.use_seed ? kbsc_pkg::seed_byte(pos_ff) : data_ff;
   assign ks_t     = last_ff[15:0] | 16'h0002;
   assign ks_prod  = ks_t * (ks_t ^ 16'h0001);
   assign mix_next = prod_ff + 32'd1;

   assign stat.pos_last = (pos_ff == kbsc_pkg::SEED_LAST);
   assign rsp_tdata     = out_data_ff;
   assign rsp_tlast     = out_eor_ff;

   always_comb begin
      first_in = first_ff;
      mix_in   = mix_ff;
      last_in  = last_ff;
      if (cmd.load_keys) begin
         first_in = kbsc_pkg::START_KEY_FIRST;
         mix_in   = kbsc_pkg::START_KEY_MIX;
         last_in  = kbsc_pkg::START_KEY_LAST;
         priority if (key_sel == kbsc_pkg::KEY_SEL_FIRST) begin
            first_in = offset_ff;
         end else if (key_sel == kbsc_pkg::KEY_SEL_MIX) begin
            mix_in = offset_ff;
         end else begin
            last_in = offset_ff;
         end
      end
      if (cmd.step_a) begin
         first_in = kbsc_pkg::crc_byte(first_ff, byte_src);
      end
      if (cmd.step_c) begin
         mix_in  = mix_next;
         last_in = kbsc_pkg::crc_byte(last_ff, mix_next[31:24]);
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_clr) begin
         pos_in = '0;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         mix_ff   <= '0;
         last_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         first_ff <= first_in;
         mix_ff   <= mix_in;
         last_ff  <= last_in;
         pos_ff   <= pos_in;
      end
   end

   // payload, product and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         offset_ff <= req_tdata[31:0];
         data_ff   <= req_tdata[39:32];
         eor_ff    <= req_tlast;
      end
      if (cmd.step_b) begin
         prod_ff <= (mix_ff + {24'h0, first_ff[7:0]}) * kbsc_pkg::MIX_MULT;
      end
      if (cmd.out_load) begin
         out_data_ff <= data_ff ^ ks_prod[15:8];
         out_eor_ff  <= eor_ff;
      end
   end

endmodule

// ===== rtl/core/keyed_byte_stream_cipher_top.sv =====
`timescale 1ns / 1ps
// data word: result loaded in step A once the output register is free, ready again when the key update ends
// init word: ready again when the key update ends for the last seed byte: one load step then
// a key update per seed byte for 32 seed bytes
// the key update runs as crc step, 32x32 multiply, crc step (STEP_A, STEP_B, STEP_C)
// a finished result waits in the output register while the next word is taken
// reset is synchronous active high: clears keys, seed position and handshake state

module keyed_byte_stream_cipher_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kbsc_pkg::REQ_TDATA_W-1:0]   req_tdata,   // offset [31:0], data_in [39:32]
   input  logic                               req_tuser,   // func: 0 init keys, 1 data byte
   input  logic                               req_tlast,   // end_of_run
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kbsc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // data_out [7:0]
   output logic                               rsp_tlast    // end_of_run_out
);

   // command and status between sequencer and key datapath
   kbsc_pkg::kbsc_cmd_type  cmd;
   kbsc_pkg::kbsc_stat_type stat;

   // sequencer: word acceptance, seed walk and result handshake
   kbsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // keys, keystream byte and result word
   kbsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
